// File: src/lvd_pkg.sv
// Shared constants, types and helpers for the edit distance block.
package lvd_pkg;

  // Longest query word the cell row can hold
  localparam int MAX_LEN = 32;

  localparam int VAL_W     = 6;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int WORDS     = 4;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);

  localparam logic [VAL_W-1:0] SAT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LEN = 3'd0,
    REG_CHARS_A   = 3'd1,
    REG_CHARS_B   = 3'd2,
    REG_CHARS_C   = 3'd3,
    REG_CHARS_D   = 3'd4
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } seq_state_e;

  // Data handed from one cell to the next as the update wave moves down the row
  typedef struct packed {
    logic              step;  // wave present at this link
    logic [CHAR_W-1:0] ch;    // candidate character being applied
    logic [VAL_W-1:0]  left;  // new value of the cell to the left
    logic [VAL_W-1:0]  diag;  // old value of the cell to the left
  } cell_link_t;

  // Increment that sticks at the top value
  function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? SAT_MAX : v + VAL_W'(1);
  endfunction

endpackage

// File: src/lvd_if.sv
// Request channels of the edit distance block: character input, result output, configuration.
interface lvd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lvd_pkg::CHAR_W-1:0] ch;
  logic                      no_char;
  logic                      last;

  modport source (output valid, ch, no_char, last, input ready);
  modport sink   (input valid, ch, no_char, last, output ready);
endinterface

interface lvd_out_if;
  logic                      valid;
  logic                      ready;
  logic [lvd_pkg::VAL_W-1:0] distance;
  logic [lvd_pkg::VAL_W-1:0] cand_length;

  modport source (output valid, distance, cand_length, input ready);
  modport sink   (input valid, distance, cand_length, output ready);
endinterface

interface lvd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lvd_pkg::CFG_IDX_W-1:0] index;
  logic [lvd_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/lvd_cell.sv
// One cell of the row: holds one entry of the distance row and passes the update wave on.
module lvd_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic [lvd_pkg::VAL_W-1:0]   init_i,
  input  logic [lvd_pkg::CHAR_W-1:0]  qchar_i,
  input  lvd_pkg::cell_link_t         link_i,
  output lvd_pkg::cell_link_t         link_o,
  output logic [lvd_pkg::VAL_W-1:0]   val_o
);

  logic [lvd_pkg::VAL_W-1:0] val_q;
  logic                      fresh_q;
  logic [lvd_pkg::VAL_W-1:0] cur;
  logic [lvd_pkg::VAL_W-1:0] up_inc;
  logic [lvd_pkg::VAL_W-1:0] left_inc;
  logic [lvd_pkg::VAL_W-1:0] sub_cost;
  logic [lvd_pkg::VAL_W-1:0] min_ul;
  logic [lvd_pkg::VAL_W-1:0] new_val;
  lvd_pkg::cell_link_t       link_q;

  // a fresh cell reads as its start value
  assign cur   = fresh_q ? init_i : val_q;
  assign val_o = cur;

  // min of delete, insert and substitute costs
  always_comb begin
    up_inc   = lvd_pkg::sat_inc(cur);
    left_inc = lvd_pkg::sat_inc(link_i.left);
    sub_cost = (link_i.ch == qchar_i) ? link_i.diag : lvd_pkg::sat_inc(link_i.diag);
    min_ul   = (left_inc < up_inc) ? left_inc : up_inc;
    new_val  = (sub_cost < min_ul) ? sub_cost : min_ul;
  end

  // fresh flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else if (clear_i) begin
      fresh_q <= 1'b1;
    end else if (link_i.step) begin
      fresh_q <= 1'b0;
    end
  end

  // stored entry
  always_ff @(posedge clk_i) begin
    if (link_i.step) begin
      val_q <= new_val;
    end
  end

  // wave marker and payload to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q.step <= link_i.step;
      link_q.ch   <= link_i.ch;
      link_q.left <= new_val;
      link_q.diag <= cur;
    end
  end

  assign link_o = link_q;

endmodule

// File: src/levenshtein_distance.sv
// Top level of the edit distance block: configuration, sequencer, cell row and result register.
// Levenshtein distance of a streamed candidate word against a query word of up to MAX_LEN
// bytes held in configuration. Each character request is launched from entry 0 and its
// update then ripples down a row of MAX_LEN cells, one cell per cycle; the next request
// is taken only once the update has left the last cell. A request with no character and
// no last flag is accepted without starting a sweep. A request marked last passes on to
// the done state, which loads the result register once it is free; the register then
// holds the distance and candidate length until taken, and the row is restored at once.
// Values saturate at 63; a query length above MAX_LEN acts as MAX_LEN.
module levenshtein_distance (
  input  logic      clk_i,
  input  logic      rst_ni,
  lvd_in_if.sink    in_i,
  lvd_cfg_if.sink   cfg_i,
  lvd_out_if.source out_o
);

  localparam int N = lvd_pkg::MAX_LEN;

  logic [lvd_pkg::VAL_W-1:0]   query_len_q;
  logic [lvd_pkg::CFG_W-1:0]   qwords_q [lvd_pkg::WORDS];
  logic [lvd_pkg::VAL_W-1:0]   row0_q;
  logic [lvd_pkg::VAL_W-1:0]   count_q;
  logic                        last_q;
  lvd_pkg::seq_state_e         state_q;
  lvd_pkg::seq_state_e         state_d;
  lvd_pkg::cell_link_t         links [N+1];
  lvd_pkg::cell_link_t         link0_q;
  logic [lvd_pkg::VAL_W-1:0]   rows [N+1];
  logic [N:0]                  step_vec;
  logic [lvd_pkg::LEN_W-1:0]   eff_len;
  logic                        in_acc;
  logic                        char_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        clear;
  logic                        out_valid_q;
  logic [lvd_pkg::VAL_W-1:0]   distance_q;
  logic [lvd_pkg::VAL_W-1:0]   cand_q;

  assign in_acc   = in_i.valid && in_i.ready;
  assign char_acc = in_acc && !in_i.no_char;
  assign out_free = !out_valid_q || out_o.ready;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_len_q <= '0;
      for (int w = 0; w < lvd_pkg::WORDS; w++) begin
        qwords_q[w] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lvd_pkg::REG_QUERY_LEN: query_len_q <= cfg_i.data[lvd_pkg::VAL_W-1:0];
        lvd_pkg::REG_CHARS_A:   qwords_q[0] <= cfg_i.data;
        lvd_pkg::REG_CHARS_B:   qwords_q[1] <= cfg_i.data;
        lvd_pkg::REG_CHARS_C:   qwords_q[2] <= cfg_i.data;
        lvd_pkg::REG_CHARS_D:   qwords_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // query length clamped to the row
  assign eff_len = (query_len_q > lvd_pkg::VAL_W'(N)) ? lvd_pkg::LEN_W'(N)
                                                     : lvd_pkg::LEN_W'(query_len_q);

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lvd_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!in_i.no_char) begin
            state_d = lvd_pkg::S_SWEEP;
          end else if (in_i.last) begin
            state_d = lvd_pkg::S_DONE;
          end
        end
      end
      lvd_pkg::S_SWEEP: begin
        if (links[N].step) begin
          state_d = last_q ? lvd_pkg::S_DONE : lvd_pkg::S_IDLE;
        end
      end
      lvd_pkg::S_DONE: begin
        if (out_free) begin
          state_d = lvd_pkg::S_IDLE;
        end
      end
      default: state_d = lvd_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      lvd_pkg::S_IDLE: in_i.ready = 1'b1;
      lvd_pkg::S_DONE: out_load   = out_free;
      default: ;
    endcase
  end

  assign clear = out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lvd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_i.last;
    end
  end

  // first row entry and candidate count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= '0;
      count_q <= '0;
    end else if (clear) begin
      row0_q  <= '0;
      count_q <= '0;
    end else if (char_acc) begin
      row0_q  <= lvd_pkg::sat_inc(row0_q);
      count_q <= lvd_pkg::sat_inc(count_q);
    end
  end

  // launch the update wave into the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link0_q <= '0;
    end else begin
      link0_q.step <= char_acc;
      if (char_acc) begin
        link0_q.ch   <= in_i.ch;
        link0_q.left <= lvd_pkg::sat_inc(row0_q);
        link0_q.diag <= row0_q;
      end
    end
  end

  assign links[0] = link0_q;
  assign rows[0]  = row0_q;

  // row of cells, cell j holds entry j
  for (genvar j = 1; j <= N; j++) begin : g_cell
    lvd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .init_i  (lvd_pkg::VAL_W'(j)),
      .qchar_i (qwords_q[(j-1)/8][((j-1)%8)*8 +: 8]),
      .link_i  (links[j-1]),
      .link_o  (links[j]),
      .val_o   (rows[j])
    );
  end

  for (genvar k = 0; k <= N; k++) begin : g_step
    assign step_vec[k] = links[k].step;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      distance_q <= rows[eff_len];
      cand_q     <= count_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.distance    = distance_q;
  assign out_o.cand_length = cand_q;

  // exactly one link carries the wave during a sweep
  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lvd_pkg::S_SWEEP) |-> $onehot(step_vec))
    else $error("update wave lost or duplicated during sweep");

  // no wave outside a sweep
  a_no_stray_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lvd_pkg::S_SWEEP) |-> (step_vec == '0))
    else $error("update wave present outside sweep");

  // a result only appears after the done state
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lvd_pkg::S_DONE))
    else $error("result raised without finishing a word");

  // the row is restored once a result is loaded
  a_row_restored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (row0_q == '0) && (count_q == '0))
    else $error("row not restored after result");

endmodule
